FILE: sv/srt_pkg.sv
package srt_pkg;

    typedef enum logic [1:0] {
        OP_MOVE = 2'd0,
        OP_HOME = 2'd1,
        OP_STOP = 2'd2,
        OP_TICK = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_HOMING = 2'd1,
        MODE_MOVE   = 2'd2
    } run_mode_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ACCEL  = 2'd1,
        PH_CRUISE = 2'd2,
        PH_DECEL  = 2'd3
    } phase_t;

    // Configuration register indexes (paddr[2])
    localparam logic REG_MICROSTEP = 1'b0;
    localparam logic REG_SPEED     = 1'b1;

    localparam logic [4:0]  MICROSTEP_RESET = 5'd2;
    localparam logic [14:0] SPEED_RESET     = 15'd1000;
    localparam logic [14:0] FREQ_CAP        = 15'd20000;
    localparam logic [14:0] HOMING_FREQ     = 15'd400;

    // floor(x/3) = (x * DIV3_MULT) >> DIV3_SHIFT, exact for x < 2^20
    localparam logic [20:0] DIV3_MULT  = 21'd1398102;
    localparam int          DIV3_SHIFT = 22;

    // floor(f*2^20/32e6) = floor(f*512/15625) = (f * NCO_MULT) >> NCO_SHIFT, f < 2^15
    localparam logic [25:0] NCO_MULT  = 26'd35184373;
    localparam int          NCO_SHIFT = 30;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] target_steps;
        logic signed [31:0] measured_pos;
    } in_item_t;

    typedef struct packed {
        logic [19:0] nco_increment;
        logic        motor_on;
        logic        direction;
        logic        move_done;
        logic [1:0]  ramp_phase;
        logic [1:0]  mode_now;
    } out_item_t;

    // Classified command handed from front to back
    typedef struct packed {
        op_t         op;
        logic [31:0] goal;
        logic [31:0] pos;
        logic        dir;
        logic [14:0] cruise;
        logic [11:0] base;
        logic [2:0]  dsh;
        logic [31:0] accel;
        logic [31:0] decel;
        logic        to_decel;
    } cmd_t;

    // Status of one item before the increment is formed
    typedef struct packed {
        logic [14:0] freq;
        logic        motor_on;
        logic        direction;
        logic        move_done;
        phase_t      phase;
        run_mode_t   mode;
    } res_t;

    function automatic logic [31:0] dist32(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        if (d[31]) begin
            d = 32'd0 - d;
        end
        return d;
    endfunction

endpackage

FILE: sv/srt_front.sv
module srt_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  srt_pkg::in_item_t s_item,
    input  logic [4:0]        microstep_mode,
    input  logic [14:0]       max_speed,
    output logic              q_valid,
    input  logic              q_ready,
    output srt_pkg::cmd_t     q_cmd
);

    logic adv1, adv2, adv3;
    logic v1_reg, v2_reg, v3_reg;

    // stage 1
    srt_pkg::op_t op1_reg;
    logic [31:0]  goal1_reg, pos1_reg, total1_reg;
    logic         dir1_reg;
    logic [40:0]  prod1_reg;
    logic [11:0]  base1_reg;
    logic [2:0]   dsh1_reg;

    // stage 2
    srt_pkg::op_t op2_reg;
    logic [31:0]  goal2_reg, pos2_reg, total2_reg, raw2_reg;
    logic         dir2_reg;
    logic [14:0]  cruise2_reg;
    logic [11:0]  base2_reg;
    logic [2:0]   dsh2_reg;

    srt_pkg::cmd_t cmd3_reg;

    logic [2:0]  mlog;
    logic [2:0]  dsh_c;
    logic [11:0] base_c;
    logic [19:0] speed_x;
    logic [40:0] prod_c;
    logic [18:0] quot_c;
    logic [14:0] cruise_c;
    logic [31:0] raw_c;
    logic [31:0] sum_c;
    logic        tri_c;
    logic [31:0] half_c;

    assign adv3    = !v3_reg || q_ready;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;
    assign q_valid = v3_reg;
    assign q_cmd   = cmd3_reg;

    always_comb begin
        case (microstep_mode)
            5'd1: begin
                mlog   = 3'd0;
                base_c = 12'd900;
            end
            5'd2: begin
                mlog   = 3'd1;
                base_c = 12'd2000;
            end
            5'd4: begin
                mlog   = 3'd2;
                base_c = 12'd800;
            end
            5'd8: begin
                mlog   = 3'd3;
                base_c = 12'd1600;
            end
            5'd16: begin
                mlog   = 3'd4;
                base_c = 12'd3200;
            end
            default: begin
                mlog   = 3'd0;
                base_c = 12'd900;
            end
        endcase
        dsh_c   = mlog + 3'd1;
        // speed*40*mode/60 = (speed*2*mode)/3
        speed_x = 20'(max_speed) << dsh_c;
        prod_c  = {21'd0, speed_x} * {20'd0, srt_pkg::DIV3_MULT};
    end

    always_comb begin
        quot_c   = prod1_reg[40:srt_pkg::DIV3_SHIFT];
        cruise_c = (quot_c > 19'(srt_pkg::FREQ_CAP)) ? srt_pkg::FREQ_CAP : quot_c[14:0];
        raw_c    = (32'(cruise_c) - 32'(base1_reg)) << dsh1_reg;
    end

    always_comb begin
        sum_c  = raw2_reg + raw2_reg;
        tri_c  = total2_reg <= sum_c;
        half_c = total2_reg >> 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= s_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (adv3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && s_valid) begin
            op1_reg    <= srt_pkg::op_t'(s_item.op);
            goal1_reg  <= s_item.target_steps;
            pos1_reg   <= s_item.measured_pos;
            total1_reg <= srt_pkg::dist32(s_item.target_steps, s_item.measured_pos);
            dir1_reg   <= s_item.target_steps > s_item.measured_pos;
            prod1_reg  <= prod_c;
            base1_reg  <= base_c;
            dsh1_reg   <= dsh_c;
        end
        if (adv2 && v1_reg) begin
            op2_reg     <= op1_reg;
            goal2_reg   <= goal1_reg;
            pos2_reg    <= pos1_reg;
            total2_reg  <= total1_reg;
            dir2_reg    <= dir1_reg;
            cruise2_reg <= cruise_c;
            raw2_reg    <= raw_c;
            base2_reg   <= base1_reg;
            dsh2_reg    <= dsh1_reg;
        end
        if (adv3 && v2_reg) begin
            cmd3_reg.op       <= op2_reg;
            cmd3_reg.goal     <= goal2_reg;
            cmd3_reg.pos      <= pos2_reg;
            cmd3_reg.dir      <= dir2_reg;
            cmd3_reg.cruise   <= cruise2_reg;
            cmd3_reg.base     <= base2_reg;
            cmd3_reg.dsh      <= dsh2_reg;
            // short move: split into a triangle
            cmd3_reg.accel    <= tri_c ? half_c : raw2_reg;
            cmd3_reg.decel    <= tri_c ? (total2_reg - half_c) : raw2_reg;
            cmd3_reg.to_decel <= tri_c;
        end
    end

endmodule

FILE: sv/srt_queue.sv
module srt_queue #(
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  srt_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output srt_pkg::cmd_t out_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    srt_pkg::cmd_t   mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic            push, pop;

    assign in_ready  = count_reg != CW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

FILE: sv/srt_back.sv
module srt_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  srt_pkg::cmd_t q_cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output srt_pkg::res_t res
);

    srt_pkg::run_mode_t mode_reg, mode_next;
    srt_pkg::phase_t    phase_reg, phase_next;
    logic               enable_reg, enable_next;
    logic               dir_reg, dir_next;
    logic [14:0]        freq_reg, freq_next;
    logic [31:0]        start_reg, goal_reg, accel_reg, decel_reg;
    logic [14:0]        cruise_reg;
    logic [11:0]        base_reg;
    logic [2:0]         dsh_reg;
    logic               to_decel_reg;
    logic               res_valid_reg;
    srt_pkg::res_t      res_reg;

    logic               pop, done;
    logic [31:0]        moved, remaining;
    logic [14:0]        ramp_moved, ramp_rem;
    srt_pkg::phase_t    ph;

    function automatic logic [14:0] ramp_freq(input logic [31:0] count, input logic [11:0] base,
                                              input logic [14:0] cruise, input logic [2:0] dsh);
        logic [31:0] sh;
        logic [32:0] sum;
        sh  = count >> dsh;
        sum = {1'b0, sh} + 33'(base);
        if (sum > 33'(cruise)) begin
            return cruise;
        end
        return sum[14:0];
    endfunction

    assign q_ready   = !res_valid_reg || res_ready;
    assign pop       = q_valid && q_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb begin
        moved      = srt_pkg::dist32(q_cmd.pos, start_reg);
        remaining  = srt_pkg::dist32(goal_reg, q_cmd.pos);
        ramp_moved = ramp_freq(moved, base_reg, cruise_reg, dsh_reg);
        ramp_rem   = ramp_freq(remaining, base_reg, cruise_reg, dsh_reg);

        mode_next   = mode_reg;
        phase_next  = phase_reg;
        enable_next = enable_reg;
        dir_next    = dir_reg;
        freq_next   = freq_reg;
        done        = 1'b0;
        ph          = phase_reg;

        case (q_cmd.op)
            srt_pkg::OP_MOVE: begin
                mode_next   = srt_pkg::MODE_MOVE;
                phase_next  = srt_pkg::PH_ACCEL;
                enable_next = 1'b1;
                dir_next    = q_cmd.dir;
                freq_next   = 15'(q_cmd.base);
            end
            srt_pkg::OP_HOME: begin
                mode_next   = srt_pkg::MODE_HOMING;
                enable_next = 1'b1;
                dir_next    = 1'b0;
                freq_next   = srt_pkg::HOMING_FREQ;
            end
            srt_pkg::OP_STOP: begin
                mode_next   = srt_pkg::MODE_IDLE;
                phase_next  = srt_pkg::PH_IDLE;
                enable_next = 1'b0;
            end
            srt_pkg::OP_TICK: begin
                if (mode_reg == srt_pkg::MODE_MOVE) begin
                    if (remaining < 32'd2) begin
                        mode_next   = srt_pkg::MODE_IDLE;
                        phase_next  = srt_pkg::PH_IDLE;
                        enable_next = 1'b0;
                        done        = 1'b1;
                    end else begin
                        if (ph == srt_pkg::PH_ACCEL) begin
                            if (moved >= accel_reg) begin
                                freq_next = cruise_reg;
                                ph = to_decel_reg ? srt_pkg::PH_DECEL : srt_pkg::PH_CRUISE;
                            end else begin
                                freq_next = ramp_moved;
                            end
                        end else if (ph == srt_pkg::PH_CRUISE) begin
                            if (remaining <= decel_reg) begin
                                ph = srt_pkg::PH_DECEL;
                            end
                        end
                        if (ph == srt_pkg::PH_DECEL) begin
                            freq_next = ramp_rem;
                        end
                        phase_next = ph;
                    end
                end
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= srt_pkg::MODE_IDLE;
            phase_reg     <= srt_pkg::PH_IDLE;
            enable_reg    <= 1'b0;
            dir_reg       <= 1'b0;
            freq_reg      <= srt_pkg::HOMING_FREQ;
            res_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                mode_reg   <= mode_next;
                phase_reg  <= phase_next;
                enable_reg <= enable_next;
                dir_reg    <= dir_next;
                freq_reg   <= freq_next;
            end
            if (q_ready) begin
                res_valid_reg <= q_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            res_reg.freq      <= freq_next;
            res_reg.motor_on  <= enable_next;
            res_reg.direction <= dir_next;
            res_reg.move_done <= done;
            res_reg.phase     <= phase_next;
            res_reg.mode      <= mode_next;
        end
        // latch the move profile
        if (pop && q_cmd.op == srt_pkg::OP_MOVE) begin
            start_reg    <= q_cmd.pos;
            goal_reg     <= q_cmd.goal;
            accel_reg    <= q_cmd.accel;
            decel_reg    <= q_cmd.decel;
            cruise_reg   <= q_cmd.cruise;
            base_reg     <= q_cmd.base;
            dsh_reg      <= q_cmd.dsh;
            to_decel_reg <= q_cmd.to_decel;
        end
    end

endmodule

FILE: sv/srt_nco_out.sv
module srt_nco_out (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               res_valid,
    output logic               res_ready,
    input  srt_pkg::res_t      res,
    output logic               m_valid,
    input  logic               m_ready,
    output srt_pkg::out_item_t m_item
);

    logic               m_valid_reg;
    srt_pkg::out_item_t m_item_reg;
    logic [40:0]        prod;
    logic [10:0]        inc;

    assign res_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    always_comb begin
        prod = {26'd0, res.freq} * {15'd0, srt_pkg::NCO_MULT};
        inc  = prod[40:srt_pkg::NCO_SHIFT];
        if (inc == '0) begin
            inc = 11'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_item_reg.nco_increment <= 20'(inc);
            m_item_reg.motor_on      <= res.motor_on;
            m_item_reg.direction     <= res.direction;
            m_item_reg.move_done     <= res.move_done;
            m_item_reg.ramp_phase    <= 2'(res.phase);
            m_item_reg.mode_now      <= 2'(res.mode);
        end
    end

endmodule

FILE: sv/stepper_trapezoid_ramp_core.sv
// Trapezoidal stepper ramp generator.
// Input channel (s_valid/s_ready/s_item) takes one command per item: start a
// move, start homing, stop, or a position tick. Each item yields exactly one
// result on the output channel (m_valid/m_ready/m_item) carrying the NCO
// increment and the motor status flags, in input order.
// Microstep mode and max speed are written over the APB port (byte address 0
// and 4); writes with out-of-range values are dropped. Write them only while
// no items are in flight.
// Path: the edge that accepts the item loads the first of three classify
// stages, then the queue, the state update and the increment multiply
// registers follow, after which m_valid rises. Throughput is one item per
// cycle while m_ready is high; the back-end state update reads back its
// own registered state for each item.
// A QUEUE_DEPTH-entry queue separates the front from the back; it and the
// front stages let the block keep accepting while a result waits. When
// m_ready stays low the pipeline fills and s_ready drops.
// Reset clears the pipeline and returns to idle with the 400 Hz increment,
// microstep mode 2 and max speed 1000.
module stepper_trapezoid_ramp_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  srt_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output srt_pkg::out_item_t m_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [4:0]    mode_reg, mode_next;
    logic [14:0]   speed_reg, speed_next;
    logic          cfg_wr;

    logic          fq_valid, fq_ready;
    srt_pkg::cmd_t fq_cmd;
    logic          qb_valid, qb_ready;
    srt_pkg::cmd_t qb_cmd;
    logic          res_valid, res_ready;
    srt_pkg::res_t res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        mode_next  = mode_reg;
        speed_next = speed_reg;
        if (cfg_wr) begin
            case (paddr[2])
                srt_pkg::REG_MICROSTEP: begin
                    if (pwdata[4:0] inside {5'd1, 5'd2, 5'd4, 5'd8, 5'd16}) begin
                        mode_next = pwdata[4:0];
                    end
                end
                srt_pkg::REG_SPEED: begin
                    if (pwdata[14:0] inside {[15'd1:srt_pkg::FREQ_CAP]}) begin
                        speed_next = pwdata[14:0];
                    end
                end
                default: begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            srt_pkg::REG_MICROSTEP: prdata = {27'd0, mode_reg};
            srt_pkg::REG_SPEED:     prdata = {17'd0, speed_reg};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= srt_pkg::MICROSTEP_RESET;
            speed_reg <= srt_pkg::SPEED_RESET;
        end else begin
            mode_reg  <= mode_next;
            speed_reg <= speed_next;
        end
    end

    srt_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_item         (s_item),
        .microstep_mode (mode_reg),
        .max_speed      (speed_reg),
        .q_valid        (fq_valid),
        .q_ready        (fq_ready),
        .q_cmd          (fq_cmd)
    );

    srt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    srt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_cmd     (qb_cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    srt_nco_out u_nco_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    // A finished move reports the motor off and the block idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.move_done |-> !m_item.motor_on &&
            m_item.mode_now == 2'(srt_pkg::MODE_IDLE) &&
            m_item.ramp_phase == 2'(srt_pkg::PH_IDLE))
        else $error("move_done without idle status");

    // While moving the ramp is always in a live phase
    a_move_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.mode_now == 2'(srt_pkg::MODE_MOVE) |->
            m_item.ramp_phase != 2'(srt_pkg::PH_IDLE))
        else $error("moving with idle ramp phase");

    // Increment never reaches zero
    a_inc_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.nco_increment != 20'd0)
        else $error("zero NCO increment");

    // Queue and back stage stay empty through reset
    a_reset_flush: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !res_valid && !qb_valid)
        else $error("pipeline not flushed by reset");

endmodule
